[rtl/core/edf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package edf_pkg;

	// Task slots held in the state memory
	localparam int NUM_TASKS = 16;
	localparam int IDX_W     = $clog2(NUM_TASKS);
	localparam int CNT_W     = $clog2(NUM_TASKS + 1);

	// Deadline countdown: two's complement, saturates at the most negative value
	localparam int CD_W = 18;
	localparam logic signed [CD_W-1:0] CD_MIN = {1'b1, {(CD_W-1){1'b0}}};

	// Input word function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// One task's record as stored in the state memory
	typedef struct packed {
		logic [15:0]            capacity;
		logic [15:0]            deadline;
		logic [15:0]            period;
		logic [15:0]            budget;
		logic signed [CD_W-1:0] countdown;
		logic [15:0]            phase;
	} task_rec_t;

	localparam int REC_W = $bits(task_rec_t);

endpackage

`default_nettype wire

[rtl/core/edf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data
module edf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/core/edf_task_upd.sv]
`timescale 1ns / 1ps
`default_nettype none

// Per-tick update of one task record: release, countdown, phase advance
module edf_task_upd
	import edf_pkg::*;
(
	input  task_rec_t rec_in,
	output task_rec_t rec_out
);

	logic [16:0] phase_inc;

	assign phase_inc = {1'b0, rec_in.phase} + 17'd1;

	always_comb begin
		rec_out = rec_in;
		// release at phase zero, else count down toward the floor
		if (rec_in.phase == 16'd0) begin
			rec_out.budget    = rec_in.capacity;
			rec_out.countdown = signed'({{(CD_W-16){1'b0}}, rec_in.deadline});
		end else if (rec_in.countdown != CD_MIN) begin
			rec_out.countdown = rec_in.countdown - {{(CD_W-1){1'b0}}, 1'b1};
		end
		// phase wraps at the period (a zero period wraps at once)
		if (phase_inc >= {1'b0, rec_in.period}) begin
			rec_out.phase = 16'd0;
		end else begin
			rec_out.phase = phase_inc[15:0];
		end
	end

endmodule

`default_nettype wire

[rtl/core/edf_periodic_task_scheduler_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake            Word
// -------  -------------------  -------------------------------------------------
// in       in_valid / in_ready  func, slot, capacity, rel_deadline, period_len
// out      out_valid/ out_ready busy_res, running_slot (one word per tick)
// cfg      cfg_we               cfg_wdata -> task_count
//
// A load word writes the slot's record straight into the memory.
// A tick word makes one memory read per slot for n = min(task_count, NUM_TASKS)
// slots, each loaded slot written back in the cycle after its read, then one write
// for the chosen budget if a task was chosen, all through the single state memory.
// Reset clears task_count, the loaded bits and the control; the memory needs none.
// A finished word waits in the output register while new input words are taken.
module edf_periodic_task_scheduler_top
	import edf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        func,
	input  wire logic [3:0]  slot,
	input  wire logic [15:0] capacity,
	input  wire logic [15:0] rel_deadline,
	input  wire logic [15:0] period_len,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             busy_res,
	output logic [3:0]       running_slot,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata
);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIX, S_OUT} state_t;

	state_t                 state_q;
	logic [4:0]             task_count_q;
	logic [NUM_TASKS-1:0]   loaded_q;
	logic [CNT_W-1:0]       rd_cnt_q;
	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   found_q;
	logic [IDX_W-1:0]       best_idx_q;
	task_rec_t              best_rec_q;

	logic [CNT_W-1:0]       n_lim;
	logic                   in_acc;
	logic                   slot_ok;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	task_rec_t              mem_wdata;
	task_rec_t              mem_rdata;
	task_rec_t              upd;
	logic                   take_s1;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign slot_ok  = (32'(slot) < NUM_TASKS);

	// Active slot count, clamped to the memory depth
	always_comb begin
		if (32'(task_count_q) > NUM_TASKS) begin
			n_lim = CNT_W'(NUM_TASKS);
		end else begin
			n_lim = CNT_W'(task_count_q);
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= 5'd0;
		end else if (cfg_we) begin
			task_count_q <= cfg_wdata;
		end
	end

	// State memory
	edf_ram #(
		.WIDTH (REC_W),
		.DEPTH (NUM_TASKS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_cnt_q[IDX_W-1:0]),
		.rdata (mem_rdata)
	);

	edf_task_upd u_upd (
		.rec_in  (mem_rdata),
		.rec_out (upd)
	);

	// Candidate check on the record coming back from memory
	assign take_s1 = vld_s1 && loaded_q[idx_s1] && (upd.budget != 16'd0) &&
		(!found_q || (upd.countdown < best_rec_q.countdown));

	// Write port: load, scan write-back, chosen budget decrement
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = upd;
		if (state_q == S_IDLE) begin
			mem_we    = in_acc && (func == FUNC_LOAD) && slot_ok;
			mem_waddr = IDX_W'(slot);
			mem_wdata = '{capacity: capacity, deadline: rel_deadline, period: period_len,
				budget: 16'd0, countdown: '0, phase: 16'd0};
		end else if (state_q == S_SCAN) begin
			mem_we = vld_s1 && loaded_q[idx_s1];
		end else if (state_q == S_FIX) begin
			mem_we           = found_q;
			mem_waddr        = best_idx_q;
			mem_wdata        = best_rec_q;
			mem_wdata.budget = best_rec_q.budget - 16'd1;
		end
	end

	// Sequencer, scan pipeline and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			loaded_q     <= '0;
			rd_cnt_q     <= '0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			found_q      <= 1'b0;
			best_idx_q   <= '0;
			best_rec_q   <= '0;
			out_valid    <= 1'b0;
			busy_res     <= 1'b0;
			running_slot <= 4'd0;
		end else begin
			// in S_OUT a taken word is replaced by the new one below
			if (out_valid && out_ready && (state_q != S_OUT)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (func == FUNC_TICK) begin
							state_q  <= S_SCAN;
							rd_cnt_q <= '0;
							vld_s1   <= 1'b0;
							found_q  <= 1'b0;
						end else if (slot_ok) begin
							loaded_q[IDX_W'(slot)] <= 1'b1;
						end
					end
				end
				S_SCAN: begin
					if (take_s1) begin
						found_q    <= 1'b1;
						best_idx_q <= idx_s1;
						best_rec_q <= upd;
					end
					if (rd_cnt_q < n_lim) begin
						vld_s1   <= 1'b1;
						idx_s1   <= rd_cnt_q[IDX_W-1:0];
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end else begin
						vld_s1  <= 1'b0;
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid    <= 1'b1;
						busy_res     <= found_q;
						running_slot <= found_q ? 4'(best_idx_q) : 4'd0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/edf_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the scheduler
module edf_chk
	import edf_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        func,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        busy_res,
	input wire logic [3:0]  running_slot
);

	// a waiting result word holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(busy_res) && $stable(running_slot))
		else $error("result word changed while stalled");

	// idle ticks report slot zero
	a_idle_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> running_slot == 4'd0)
		else $error("idle result with nonzero slot");

	// a reported slot lies inside the table
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && busy_res |-> 32'(running_slot) < NUM_TASKS)
		else $error("running slot beyond table");

	// a tick occupies the block: input closes for at least the next cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FUNC_TICK |=> !in_ready)
		else $error("input open right after a tick");

endmodule

bind edf_periodic_task_scheduler_top edf_chk u_edf_chk (.*);

`default_nettype wire
